[sv/puf_pkg.sv]
// shared types and constants for the parity union-find unit
package puf_pkg;

    typedef enum logic [1:0] {
        ACT_MERGE_ALIKE   = 2'd0,
        ACT_MERGE_OPPOSED = 2'd1,
        ACT_ASK_ALIKE     = 2'd2,
        ACT_ASK_OPPOSED   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_COMP_RD,
        ST_COMP_WR,
        ST_SIZE_RD,
        ST_SIZE_CHK,
        ST_MERGE_WR,
        ST_DONE
    } t_state;

endpackage

[sv/parity_union_find_unit.sv]
// parity union-find unit: disjoint-set table with link parity in on-chip memory
//
// One request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_valid high. The receiver cannot stall, so
// busy stays high through the cycle before that result and is low in the result
// cycle. After reset a clearing pass writes every node of the memory; busy is high
// meanwhile. All accesses are serialized on the single-port node memory, whose
// read data is registered. A find reads each node from the start up to the root,
// then walks the path again from the start, rewriting each link to point at the
// root, and then reads the root's size. A request finds a, then b; a merge that
// joins two sets also writes the surviving root's combined size. The next request
// can be taken at the end of the result cycle. Union by size bounds each path at
// log2(ELEMENTS) links.
module parity_union_find_unit #(
    parameter int ELEMENTS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [9:0] i_elem_a,
    input  logic [9:0] i_elem_b,
    output logic       o_valid,
    output logic       o_answer,
    output logic       o_conflict
);
    import puf_pkg::*;

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int SW = AW + 1;
    localparam int NW = 2 + AW + SW; // root, parity, parent, size

    // node word: {is_root, parity, parent, size}
    logic [NW-1:0] r_mem [ELEMENTS];
    logic [NW-1:0] r_rd;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [NW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    logic          rd_root, rd_par;
    logic [AW-1:0] rd_parent;
    logic [SW-1:0] rd_size;
    assign {rd_root, rd_par, rd_parent, rd_size} = r_rd;

    t_state r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;      // clear index / walk step count
    logic [1:0]    r_act, n_act;
    logic [AW-1:0] r_a, n_a, r_b, n_b;
    logic          r_side, n_side;    // 0 finding a, 1 finding b
    logic [AW-1:0] r_cur, n_cur;
    logic          r_p, n_p;          // accumulated parity
    logic [AW-1:0] r_root, n_root;
    logic          r_tot, n_tot;
    logic [AW-1:0] r_ra, n_ra;
    logic          r_pa, n_pa;
    logic [SW-1:0] r_sa, n_sa;
    logic          r_ans, n_ans, r_cfl, n_cfl, r_val, n_val;
    logic          r_steps_full, n_steps_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_val   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_val   <= n_val;
        end
        r_act <= n_act; r_a <= n_a; r_b <= n_b; r_side <= n_side;
        r_cur <= n_cur; r_p <= n_p; r_root <= n_root; r_tot <= n_tot;
        r_ra <= n_ra; r_pa <= n_pa; r_sa <= n_sa;
        r_ans <= n_ans; r_cfl <= n_cfl; r_steps_full <= n_steps_full;
    end

    logic in_range;
    assign in_range = (32'(i_elem_a) < 32'(ELEMENTS)) && (32'(i_elem_b) < 32'(ELEMENTS));

    logic [SW-1:0] one_size;
    assign one_size = SW'(1);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_act = r_act; n_a = r_a; n_b = r_b;
        n_side = r_side; n_cur = r_cur; n_p = r_p; n_root = r_root; n_tot = r_tot;
        n_ra = r_ra; n_pa = r_pa; n_sa = r_sa; n_ans = r_ans; n_cfl = r_cfl;
        n_val = 1'b0; n_steps_full = r_steps_full;
        mem_addr = r_cur; mem_we = 1'b0; mem_wd = r_rd;
        case (r_state)
            ST_CLEAR: begin
                mem_addr = r_cnt; mem_we = 1'b1;
                mem_wd = {1'b1, 1'b0, {AW{1'b0}}, one_size};
                n_cnt = r_cnt + AW'(1);
                if (32'(r_cnt) == ELEMENTS - 1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    n_act = i_action; n_a = AW'(i_elem_a); n_b = AW'(i_elem_b);
                    n_ans = 1'b0; n_cfl = 1'b0;
                    if (in_range) begin
                        n_side = 1'b0; n_cur = AW'(i_elem_a); n_p = 1'b0;
                        n_cnt = '0; n_steps_full = 1'b0;
                        n_state = ST_WALK_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK_RD: begin
                mem_addr = r_cur; n_state = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (rd_root || r_steps_full) begin
                    // root found; restart at node for compression
                    n_root = r_cur; n_tot = r_p;
                    n_cur = r_side ? r_b : r_a;
                    n_cnt = '0; n_steps_full = 1'b0;
                    n_state = ST_COMP_RD;
                end else begin
                    n_p = r_p ^ rd_par; n_cur = rd_parent;
                    n_cnt = r_cnt + AW'(1);
                    if (32'(r_cnt) == ELEMENTS - 1) n_steps_full = 1'b1;
                    n_state = ST_WALK_RD;
                end
            end
            ST_COMP_RD: begin
                mem_addr = r_cur;
                if (r_cur == r_root || r_steps_full) n_state = ST_SIZE_RD;
                else n_state = ST_COMP_WR;
            end
            ST_COMP_WR: begin
                mem_addr = r_cur;
                if (rd_root) begin
                    n_state = ST_SIZE_RD;
                end else begin
                    mem_we = 1'b1;
                    mem_wd = {1'b0, r_tot, r_root, rd_size};
                    n_tot = r_tot ^ rd_par; n_cur = rd_parent;
                    n_cnt = r_cnt + AW'(1);
                    if (32'(r_cnt) == ELEMENTS - 1) n_steps_full = 1'b1;
                    n_state = ST_COMP_RD;
                end
            end
            ST_SIZE_RD: begin
                // read the root's size
                mem_addr = r_root; n_state = ST_SIZE_CHK;
            end
            ST_SIZE_CHK: begin
                if (!r_side) begin
                    n_ra = r_root; n_pa = r_p; n_sa = rd_size;
                    n_side = 1'b1; n_cur = r_b; n_p = 1'b0;
                    n_cnt = '0; n_steps_full = 1'b0;
                    n_state = ST_WALK_RD;
                end else begin
                    n_state = ST_DONE;
                    if (r_act[1]) begin
                        n_ans = (r_ra == r_root) && ((r_pa ^ r_p) == r_act[0]);
                    end else if (r_ra == r_root) begin
                        n_cfl = (r_pa ^ r_p) != r_act[0];
                    end else begin
                        mem_we = 1'b1;
                        if (rd_size > r_sa) begin
                            // a's root joins under b's root
                            mem_addr = r_ra;
                            mem_wd = {1'b0, r_pa ^ r_p ^ r_act[0], r_root, r_sa};
                            n_cur = r_root;
                        end else begin
                            mem_addr = r_root;
                            mem_wd = {1'b0, r_pa ^ r_p ^ r_act[0], r_ra, rd_size};
                            n_cur = r_ra;
                        end
                        n_sa = rd_size + r_sa;
                        n_state = ST_MERGE_WR;
                    end
                end
            end
            ST_MERGE_WR: begin
                // surviving root takes the combined size
                mem_addr = r_cur; mem_we = 1'b1;
                mem_wd = {1'b1, 1'b0, {AW{1'b0}}, r_sa};
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_val = 1'b1; n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_valid    = r_val;
    assign o_answer   = r_ans;
    assign o_conflict = r_cfl;

endmodule

[sim/tb_parity_union_find_unit.sv]
// testbench for the parity union-find unit: directed and random requests checked against a predictor
module tb_parity_union_find_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import puf_pkg::*;

    localparam int N = 1024;
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_action = ACT_MERGE_ALIKE;
    logic [9:0] i_elem_a = '0;
    logic [9:0] i_elem_b = '0;
    logic       o_valid;
    logic       o_answer;
    logic       o_conflict;

    parity_union_find_unit #(.ELEMENTS(N)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_elem_a(i_elem_a), .i_elem_b(i_elem_b),
        .o_valid(o_valid), .o_answer(o_answer), .o_conflict(o_conflict)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct packed {
        logic answer;
        logic conflict;
    } t_outcome;

    // predictor copy of the table
    logic        root_flag [N];
    logic [9:0]  up_link   [N];
    logic [10:0] grp_size  [N];
    logic        up_par    [N];

    t_outcome outcome_q[$];
    int mismatches = 0;
    int cycles = 0;

    function automatic logic [9:0] walk_root(input logic [9:0] node, output logic par);
        logic [9:0] cur;
        logic [9:0] nxt;
        logic [9:0] top;
        logic       p;
        logic       lk;
        cur = node;
        p = 1'b0;
        while (!root_flag[cur]) begin
            p ^= up_par[cur];
            cur = up_link[cur];
        end
        top = cur;
        par = p;
        cur = node;
        while (cur != top) begin
            nxt = up_link[cur];
            lk = up_par[cur];
            up_link[cur] = top;
            up_par[cur] = p;
            p ^= lk;
            cur = nxt;
        end
        return top;
    endfunction

    function automatic t_outcome apply_request(input t_action act, input logic [9:0] a,
                                               input logic [9:0] b);
        t_outcome r;
        logic [9:0] ra, rb, big, sml;
        logic pa, pb, rel;
        r = '0;
        ra = walk_root(a, pa);
        rb = walk_root(b, pb);
        rel = pa ^ pb;
        if (act == ACT_ASK_ALIKE || act == ACT_ASK_OPPOSED) begin
            r.answer = (ra == rb) && (rel == act[0]);
        end else if (ra == rb) begin
            r.conflict = (rel != act[0]);
        end else begin
            big = ra;
            sml = rb;
            if (grp_size[rb] > grp_size[ra]) begin
                big = rb;
                sml = ra;
            end
            grp_size[big] += grp_size[sml];
            root_flag[sml] = 1'b0;
            up_link[sml] = big;
            up_par[sml] = rel ^ act[0];
        end
        return r;
    endfunction

    function automatic int gap_length();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    task automatic send_request(input t_action act, input logic [9:0] a, input logic [9:0] b);
        int n;
        start    <= 1'b1;
        i_action <= act;
        i_elem_a <= a;
        i_elem_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        outcome_q = {outcome_q, apply_request(act, a, b)};
        n = gap_length();
        // with no gap start stays high for the next transaction
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: answer=%b conflict=%b",
                                               o_answer, o_conflict);
            end else begin
                exp_r = outcome_q.pop_front();
                if (o_answer !== exp_r.answer || o_conflict !== exp_r.conflict) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected answer=%b conflict=%b, got %b %b",
                                 exp_r.answer, exp_r.conflict, o_answer, o_conflict);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(ACT_ASK_ALIKE, 10'd5, 10'd5);
        send_request(ACT_ASK_OPPOSED, 10'd5, 10'd5);
        send_request(ACT_MERGE_ALIKE, 10'd7, 10'd7);
        send_request(ACT_MERGE_OPPOSED, 10'd7, 10'd7);
        send_request(ACT_ASK_ALIKE, 10'd0, 10'd1023);
        send_request(ACT_MERGE_OPPOSED, 10'd0, 10'd1023);
        send_request(ACT_ASK_OPPOSED, 10'd1023, 10'd0);
        send_request(ACT_MERGE_ALIKE, 10'd0, 10'd1023);
        send_request(ACT_MERGE_OPPOSED, 10'd0, 10'd1023);
        // equal sizes, then bigger set on the b side
        send_request(ACT_MERGE_ALIKE, 10'd1, 10'd2);
        send_request(ACT_MERGE_OPPOSED, 10'd3, 10'd1);
        send_request(ACT_MERGE_ALIKE, 10'd0, 10'd3);
        send_request(ACT_ASK_ALIKE, 10'd2, 10'd1023);
        send_request(ACT_ASK_OPPOSED, 10'd2, 10'd1023);
        send_request(ACT_MERGE_OPPOSED, 10'd2, 10'd1023);
        send_request(ACT_ASK_ALIKE, 10'd682, 10'd341);
    endtask

    task automatic test_chains();
        // a run of merges joining neighbouring elements into one set, then random requests in a small pool
        logic [9:0] base;
        int i;
        base = 10'd512;
        for (i = 0; i < 40; i++)
            send_request(t_action'($urandom_range(0, 1)), base + i[9:0] + 10'd1,
                         base + i[9:0]);
        for (i = 0; i < 250; i++)
            send_request(t_action'($urandom_range(0, 3)),
                         base + 10'($urandom_range(0, 63)),
                         base + 10'($urandom_range(0, 63)));
    endtask

    task automatic test_random();
        int i;
        for (i = 0; i < 360; i++)
            send_request(t_action'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)));
    endtask

    initial begin
        int i;
        int waited;
        for (i = 0; i < N; i++) begin
            root_flag[i] = 1'b1;
            up_link[i] = '0;
            grp_size[i] = 11'd1;
            up_par[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_chains();
        test_random();
        start <= 1'b0;
        waited = 0;
        while (outcome_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
